[hw/rtl/rars_pkg.sv]
// Shared constants and codes for the range-add / range-sum tree block.
// No dependencies; imported by the tree top level.
`timescale 1ns / 1ps
`default_nettype none
package rars_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int VALUE_W      = 64;
  localparam int NODE_COUNT   = 4 * MAX_ELEMENTS;
  localparam int POS_W        = 11;
  localparam int ELEM_AW      = $clog2(MAX_ELEMENTS);
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int STK_DEPTH    = 16;
  localparam int STK_W        = $clog2(STK_DEPTH);
  localparam int CMD_W        = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_ENTER,
    PH_RIGHT,
    PH_FINISH
  } phase_t;

  typedef enum logic [1:0] {
    RET_POP,
    RET_LEFT,
    RET_RIGHT
  } ap_ret_t;

endpackage
`default_nettype wire

[hw/rtl/rars_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rars_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/range_add_range_sum_tree.sv]
// Lazy segment tree (range add, range sum) walked by a small sequencer.
// Depends on rars_pkg and rars_ram.
//
//  channel  signals                                           handshake
//  cmd      start, busy, cmd, range_left, range_right,         start & !busy
//           operand_value
//  result   done, range_sum                                   done, one cycle
//  config   cfg_valid, cfg_ready, cfg_data                    cfg_valid & cfg_ready
//
// Load writes the element in the accept cycle. Build visits every node: a leaf
// copies its element into the sum memory and an inner node stores the sum of
// its children. Add and query walk the tree through an explicit frame stack;
// the steps of each visited node are set by the one-port registered reads of
// the sum and tag memories. After reset all 4096 tag memory entries are
// cleared, one entry a cycle, with busy high.
// The result is shown for one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module range_add_range_sum_tree (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rars_pkg::CMD_W-1:0]    cmd,
  input  wire logic [rars_pkg::POS_W-1:0]    range_left,
  input  wire logic [rars_pkg::POS_W-1:0]    range_right,
  input  wire logic signed [rars_pkg::VALUE_W-1:0] operand_value,
  output logic                               done,
  output logic signed [rars_pkg::VALUE_W-1:0] range_sum,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rars_pkg::POS_W-1:0]    cfg_data
);
  import rars_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_DECIDE, S_PUSHL, S_PT_RD, S_PT_CHK, S_PT_CLR,
    S_AP_RD, S_AP_MUL, S_AP_WR, S_CMB0, S_CMB1, S_CMB2, S_QRD, S_QACC,
    S_BRD, S_BLEAF, S_POP
  } state_t;

  state_t state;

  logic [POS_W-1:0]   element_count;
  logic [POS_W-1:0]   n_act;
  logic [POS_W-1:0]   a_in, b_in;
  logic [NODE_W-1:0]  clr_addr;

  cmd_t               op;
  logic [POS_W-1:0]   a, b;
  logic [VALUE_W-1:0] amount;
  logic [VALUE_W-1:0] acc;

  // frame stack
  logic [POS_W-1:0]   lo_stk [STK_DEPTH];
  logic [POS_W-1:0]   hi_stk [STK_DEPTH];
  logic [NODE_W-1:0]  p_stk  [STK_DEPTH];
  phase_t             ph_stk [STK_DEPTH];
  logic [STK_W-1:0]   sp;
  logic [STK_W-1:0]   top;

  // working frame
  logic [POS_W-1:0]   lo, hi;
  logic [NODE_W-1:0]  p;
  phase_t             ph;
  logic [POS_W:0]     lo_hi;
  logic [POS_W-1:0]   mid;
  logic [NODE_W-1:0]  p_l, p_r;
  logic               cov, dis, leaf;

  // tag apply unit
  logic [NODE_W-1:0]  ap_node;
  logic [POS_W-1:0]   ap_len;
  logic [VALUE_W-1:0] ap_amt;
  ap_ret_t            ap_ret;
  logic [VALUE_W-1:0] ptag;
  logic [VALUE_W-1:0] sum_q, tag_q, prod, left_q;

  // memory ports
  logic               elem_we;
  logic [ELEM_AW-1:0] elem_waddr, elem_raddr;
  logic [VALUE_W-1:0] elem_rdata;
  logic               sum_we, tag_we;
  logic [NODE_W-1:0]  sum_waddr, sum_raddr, tag_waddr, tag_raddr;
  logic [VALUE_W-1:0] sum_wdata, sum_rdata, tag_wdata, tag_rdata;

  logic               accept;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state == S_IDLE);

  always_comb begin
    if (element_count == '0) begin
      n_act = POS_W'(1);
    end else if (element_count > POS_W'(MAX_ELEMENTS)) begin
      n_act = POS_W'(MAX_ELEMENTS);
    end else begin
      n_act = element_count;
    end
    a_in = (range_left == '0) ? POS_W'(1) : range_left;
    b_in = (range_right > n_act) ? n_act : range_right;
  end

  assign top   = sp - STK_W'(1);
  assign lo_hi = {1'b0, lo} + {1'b0, hi};
  assign mid   = lo_hi[POS_W:1];
  assign p_l   = {p[NODE_W-2:0], 1'b0};
  assign p_r   = {p[NODE_W-2:0], 1'b1};
  assign cov   = (a <= lo) && (b >= hi);
  assign dis   = (hi < a) || (lo > b);
  assign leaf  = (lo == hi);

  // element load happens in the accept cycle
  assign elem_we    = accept && (cmd_t'(cmd) == CMD_LOAD) && (range_left != '0) &&
                      (range_left <= POS_W'(MAX_ELEMENTS));
  assign elem_waddr = ELEM_AW'(range_left - POS_W'(1));
  assign elem_raddr = ELEM_AW'(lo - POS_W'(1));

  always_comb begin
    sum_raddr = p;
    tag_raddr = p;
    unique case (state)
      S_AP_RD: begin
        sum_raddr = ap_node;
        tag_raddr = ap_node;
      end
      S_CMB0:  sum_raddr = p_l;
      S_CMB1:  sum_raddr = p_r;
      default: begin
        sum_raddr = p;
        tag_raddr = p;
      end
    endcase
  end

  always_comb begin
    sum_we    = 1'b0;
    sum_waddr = p;
    sum_wdata = elem_rdata;
    tag_we    = 1'b0;
    tag_waddr = p;
    tag_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_addr;
      end
      S_DECIDE: begin
        tag_we = (op == CMD_BUILD) && (ph == PH_ENTER);
      end
      S_AP_WR: begin
        sum_we    = 1'b1;
        sum_waddr = ap_node;
        sum_wdata = sum_q + prod;
        tag_we    = 1'b1;
        tag_waddr = ap_node;
        tag_wdata = tag_q + ap_amt;
      end
      S_PT_CLR: tag_we = 1'b1;
      S_CMB2: begin
        sum_we    = 1'b1;
        sum_wdata = left_q + sum_rdata;
      end
      S_BLEAF: sum_we = 1'b1;
      default: begin
        sum_we = 1'b0;
        tag_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      element_count <= POS_W'(MAX_ELEMENTS);
      sp            <= '0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        element_count <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == NODE_W'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op     <= cmd_t'(cmd);
            a      <= a_in;
            b      <= b_in;
            amount <= operand_value;
            acc    <= '0;
            // root frame
            lo_stk[0] <= POS_W'(1);
            hi_stk[0] <= n_act;
            p_stk[0]  <= NODE_W'(1);
            ph_stk[0] <= PH_ENTER;
            unique case (cmd_t'(cmd))
              CMD_LOAD: state <= S_IDLE;
              CMD_BUILD: begin
                sp    <= STK_W'(1);
                state <= S_FETCH;
              end
              CMD_ADD: begin
                if (a_in <= b_in) begin
                  sp    <= STK_W'(1);
                  state <= S_FETCH;
                end
              end
              CMD_QUERY: begin
                if (a_in <= b_in) begin
                  sp    <= STK_W'(1);
                  state <= S_FETCH;
                end else begin
                  range_sum <= '0;
                  done      <= 1'b1;
                end
              end
            endcase
          end
        end
        S_FETCH: begin
          lo    <= lo_stk[top];
          hi    <= hi_stk[top];
          p     <= p_stk[top];
          ph    <= ph_stk[top];
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          unique case (ph)
            PH_ENTER: begin
              unique case (op)
                CMD_BUILD: state <= leaf ? S_BRD : S_PUSHL;
                CMD_ADD: begin
                  if (cov) begin
                    ap_node <= p;
                    ap_len  <= hi - lo + POS_W'(1);
                    ap_amt  <= amount;
                    ap_ret  <= RET_POP;
                    state   <= S_AP_RD;
                  end else if (dis) begin
                    state <= S_POP;
                  end else begin
                    state <= S_PT_RD;
                  end
                end
                CMD_QUERY: begin
                  if (cov) begin
                    state <= S_QRD;
                  end else if (dis) begin
                    state <= S_POP;
                  end else begin
                    state <= S_PT_RD;
                  end
                end
                default: state <= S_POP;
              endcase
            end
            PH_RIGHT: begin
              ph_stk[top] <= PH_FINISH;
              lo_stk[sp]  <= mid + POS_W'(1);
              hi_stk[sp]  <= hi;
              p_stk[sp]   <= p_r;
              ph_stk[sp]  <= PH_ENTER;
              sp          <= sp + STK_W'(1);
              state       <= S_FETCH;
            end
            default: state <= (op == CMD_QUERY) ? S_POP : S_CMB0;
          endcase
        end
        S_PUSHL: begin
          ph_stk[top] <= PH_RIGHT;
          lo_stk[sp]  <= lo;
          hi_stk[sp]  <= mid;
          p_stk[sp]   <= p_l;
          ph_stk[sp]  <= PH_ENTER;
          sp          <= sp + STK_W'(1);
          state       <= S_FETCH;
        end
        S_PT_RD: state <= S_PT_CHK;
        S_PT_CHK: begin
          if (tag_rdata == '0) begin
            state <= S_PUSHL;
          end else begin
            ptag    <= tag_rdata;
            ap_node <= p_l;
            ap_len  <= mid - lo + POS_W'(1);
            ap_amt  <= tag_rdata;
            ap_ret  <= RET_LEFT;
            state   <= S_AP_RD;
          end
        end
        S_PT_CLR: state <= S_PUSHL;
        S_AP_RD: state <= S_AP_MUL;
        S_AP_MUL: begin
          sum_q <= sum_rdata;
          tag_q <= tag_rdata;
          prod  <= VALUE_W'(ap_amt * VALUE_W'(ap_len));
          state <= S_AP_WR;
        end
        S_AP_WR: begin
          unique case (ap_ret)
            RET_LEFT: begin
              ap_node <= p_r;
              ap_len  <= hi - mid;
              ap_amt  <= ptag;
              ap_ret  <= RET_RIGHT;
              state   <= S_AP_RD;
            end
            RET_RIGHT: state <= S_PT_CLR;
            default:   state <= S_POP;
          endcase
        end
        S_CMB0: state <= S_CMB1;
        S_CMB1: begin
          left_q <= sum_rdata;
          state  <= S_CMB2;
        end
        S_CMB2: state <= S_POP;
        S_QRD:  state <= S_QACC;
        S_QACC: begin
          acc   <= acc + sum_rdata;
          state <= S_POP;
        end
        S_BRD:   state <= S_BLEAF;
        S_BLEAF: state <= S_POP;
        S_POP: begin
          sp <= top;
          if (sp == STK_W'(1)) begin
            state <= S_IDLE;
            if (op == CMD_QUERY) begin
              range_sum <= acc;
              done      <= 1'b1;
            end
          end else begin
            state <= S_FETCH;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rars_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (operand_value),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  rars_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_COUNT)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  rars_ram #(.WIDTH(VALUE_W), .DEPTH(NODE_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

endmodule
`default_nettype wire
